[hdl/efr_pkg.sv]
`timescale 1ns / 1ps

package efr_pkg;

    localparam logic [7:0] ESC_BYTE = 8'h9F;
    localparam logic [7:0] STX_BYTE = 8'h02;
    localparam logic [7:0] ETX_BYTE = 8'h03;

    localparam logic [7:0] TYPE_A = 8'h01;
    localparam logic [7:0] TYPE_B = 8'h20;
    localparam logic [7:0] TYPE_C = 8'hA0;
    localparam logic [7:0] TYPE_LONG = 8'hA2;
    localparam logic [7:0] TYPE_MID = 8'hA3;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_STX      = 3'd1,
        ERR_TYPE     = 3'd2,
        ERR_CHECKSUM = 3'd3,
        ERR_TRAILER  = 3'd4
    } err_code_t;

    // One frame result or error report, as it leaves the parser.
    typedef struct packed {
        logic       valid;
        logic       good;
        err_code_t  err;
        logic [7:0] type_code;
        logic [1:0] len;
        logic [7:0] d0;
        logic [7:0] d1;
        logic [7:0] d2;
    } result_t;

    function automatic logic type_ok(input logic [7:0] t);
        return (t == TYPE_A) || (t == TYPE_B) || (t == TYPE_C) ||
               (t == TYPE_LONG) || (t == TYPE_MID);
    endfunction

    function automatic logic [1:0] len_of(input logic [7:0] t);
        logic [1:0] n;
        case (t)
            TYPE_LONG: n = 2'd3;
            TYPE_MID:  n = 2'd2;
            default:   n = 2'd1;
        endcase
        return n;
    endfunction

endpackage

[hdl/efr_parser.sv]
`timescale 1ns / 1ps

module efr_parser
    import efr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] rx_byte,
    output result_t    result
);

    typedef enum logic [2:0] {
        PH_ESC   = 3'd0,
        PH_STX   = 3'd1,
        PH_TYPE  = 3'd2,
        PH_DATA  = 3'd3,
        PH_CHECK = 3'd4,
        PH_ETX   = 3'd5
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic       in_frame_reg, in_frame_next;
    logic [7:0] type_reg, type_next;
    logic [1:0] count_reg, count_next;
    logic [7:0] d0_reg, d0_next;
    logic [7:0] d1_reg, d1_next;
    logic [7:0] d2_reg, d2_next;
    logic [7:0] xor_reg, xor_next;

    always_comb
    begin
        logic       hunt;
        logic [1:0] cnt_inc;
        hunt          = 1'b0;
        cnt_inc       = count_reg + 2'd1;
        phase_next    = phase_reg;
        in_frame_next = in_frame_reg;
        type_next     = type_reg;
        count_next    = count_reg;
        d0_next       = d0_reg;
        d1_next       = d1_reg;
        d2_next       = d2_reg;
        xor_next      = xor_reg;
        result        = '0;

        if (accept)
        begin
            case (phase_reg)
                PH_STX:
                begin
                    if (rx_byte == STX_BYTE)
                    begin
                        phase_next = PH_TYPE;
                    end
                    else
                    begin
                        result.valid = 1'b1;
                        result.err   = ERR_STX;
                        hunt         = 1'b1;
                    end
                end
                PH_TYPE:
                begin
                    if (type_ok(rx_byte))
                    begin
                        type_next  = rx_byte;
                        xor_next   = rx_byte;
                        count_next = 2'd0;
                        d0_next    = 8'd0;
                        d1_next    = 8'd0;
                        d2_next    = 8'd0;
                        phase_next = PH_DATA;
                    end
                    else
                    begin
                        result.valid = 1'b1;
                        result.err   = ERR_TYPE;
                        hunt         = 1'b1;
                    end
                end
                PH_DATA:
                begin
                    case (count_reg)
                        2'd0:    d0_next = rx_byte;
                        2'd1:    d1_next = rx_byte;
                        2'd2:    d2_next = rx_byte;
                        default: ;
                    endcase
                    xor_next   = xor_reg ^ rx_byte;
                    count_next = cnt_inc;
                    if (cnt_inc >= len_of(type_reg))
                    begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK:
                begin
                    // in_frame stays set, so the next escape is taken as the trailer.
                    if (rx_byte == xor_reg)
                    begin
                        phase_next = PH_ESC;
                    end
                    else
                    begin
                        result.valid = 1'b1;
                        result.err   = ERR_CHECKSUM;
                        hunt         = 1'b1;
                    end
                end
                PH_ETX:
                begin
                    result.valid = 1'b1;
                    if (rx_byte == ETX_BYTE)
                    begin
                        result.good      = 1'b1;
                        result.err       = ERR_NONE;
                        result.type_code = type_reg;
                        result.len       = len_of(type_reg);
                        result.d0        = d0_reg;
                        result.d1        = d1_reg;
                        result.d2        = d2_reg;
                    end
                    else
                    begin
                        result.err = ERR_TRAILER;
                    end
                    hunt = 1'b1;
                end
                default:
                begin
                    if (rx_byte == ESC_BYTE)
                    begin
                        if (in_frame_reg)
                        begin
                            phase_next = PH_ETX;
                        end
                        else
                        begin
                            in_frame_next = 1'b1;
                            phase_next    = PH_STX;
                        end
                    end
                    else if (in_frame_reg)
                    begin
                        result.valid = 1'b1;
                        result.err   = ERR_TRAILER;
                        hunt         = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_ESC;
                    end
                end
            endcase
        end

        if (hunt)
        begin
            phase_next    = PH_ESC;
            in_frame_next = 1'b0;
            type_next     = 8'd0;
            count_next    = 2'd0;
            d0_next       = 8'd0;
            d1_next       = 8'd0;
            d2_next       = 8'd0;
            xor_next      = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_ESC;
            in_frame_reg <= 1'b0;
            type_reg     <= 8'd0;
            count_reg    <= 2'd0;
            d0_reg       <= 8'd0;
            d1_reg       <= 8'd0;
            d2_reg       <= 8'd0;
            xor_reg      <= 8'd0;
        end
        else
        begin
            phase_reg    <= phase_next;
            in_frame_reg <= in_frame_next;
            type_reg     <= type_next;
            count_reg    <= count_next;
            d0_reg       <= d0_next;
            d1_reg       <= d1_next;
            d2_reg       <= d2_next;
            xor_reg      <= xor_next;
        end
    end

endmodule

[hdl/escaped_frame_receiver.sv]
`timescale 1ns / 1ps

// Receiver for escaped serial frames: ESC STX type data[1..3] checksum ESC ETX.
// The slave channel takes one received byte per item in s_tdata. The master
// channel gives one item per completed frame or per framing error; m_tuser
// is 1 for a good frame and 0 for an error report.
// Bytes outside a frame other than the escape byte give no item.
// Throughput is one byte per cycle while s_tready is high: each byte is decoded
// combinationally against the frame state registers. A result is registered at
// the edge that accepts the byte causing it, in the output register if that is
// free or being taken (m_tvalid then rises right after that edge), else in the skid register.
// A two-entry output buffer (output register plus skid register) lets input
// continue while one result waits. When the receiver stalls and both entries
// hold results, s_tready drops until m_tready takes one.
// Reset (rst_n low, asynchronous) returns the parser to hunting for an
// escape byte and empties the output buffer.

module escaped_frame_receiver
    import efr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,  // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // [2:0] error_code, [10:3] type_code, [12:11] data_len,
                                  // [20:13] data_first, [28:21] data_second,
                                  // [36:29] data_third, [39:37] zero
    output logic [0:0]  m_tuser   // [0] frame_good
);

    result_t res;
    result_t out_reg, out_next;
    result_t skid_reg, skid_next;
    logic    accept;
    logic    pop;

    assign s_tready = !skid_reg.valid;
    assign accept   = s_tvalid && s_tready;
    assign pop      = out_reg.valid && m_tready;

    efr_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (s_tdata),
        .result  (res)
    );

    always_comb
    begin
        out_next  = out_reg;
        skid_next = skid_reg;
        if (pop)
        begin
            if (skid_reg.valid)
            begin
                out_next        = skid_reg;
                skid_next.valid = 1'b0;
            end
            else
            begin
                out_next = res;
            end
        end
        else if (!out_reg.valid)
        begin
            out_next = res;
        end
        else if (res.valid)
        begin
            skid_next = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg  <= '0;
            skid_reg <= '0;
        end
        else
        begin
            out_reg  <= out_next;
            skid_reg <= skid_next;
        end
    end

    assign m_tvalid   = out_reg.valid;
    assign m_tuser[0] = out_reg.good;
    assign m_tdata    = {3'd0, out_reg.d2, out_reg.d1, out_reg.d0, out_reg.len,
                         out_reg.type_code, out_reg.err};

endmodule

[verif/escaped_frame_receiver_tb.sv]
`timescale 1ns / 1ps

module escaped_frame_receiver_tb;
    import efr_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int ITEMS_PER_STAGE = 412;
    localparam int LAST_STAGE      = 4;
    localparam int HOLD_CYCLES     = 400;
    localparam int DRAIN_CYCLES    = 20;
    localparam int SCRIPT_LEN      = 33;
    localparam int SHOWN_MISMATCHES = 10;

    typedef enum logic [2:0] {
        HUNT      = 3'd0,
        WAIT_STX  = 3'd1,
        WAIT_TYPE = 3'd2,
        TAKE_DATA = 3'd3,
        WAIT_SUM  = 3'd4,
        WAIT_ETX  = 3'd5
    } parse_state_t;

    typedef struct packed {
        logic       good;
        err_code_t  err;
        logic [7:0] type_code;
        logic [1:0] len;
        logic [7:0] d0;
        logic [7:0] d1;
        logic [7:0] d2;
    } frame_report_t;

    // A row names the byte to send and, for error reports, the code to expect.
    // Rows with ERR_NONE are checked against the decoder model below.
    typedef struct packed {
        logic [7:0] rx;
        err_code_t  want;
    } script_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [0:0]  m_tuser;

    // Decoder model state.
    parse_state_t rx_state;
    logic         frame_open;
    logic [7:0]   frame_type_q;
    logic [1:0]   data_cnt;
    logic [7:0]   frame_data [3];
    logic [7:0]   frame_sum;

    frame_report_t pending_reports [$];

    int cycle_count = 0;
    int mismatch_count = 0;
    int bytes_sent = 0;
    int frame_bytes = 0;
    int good_frames_seen = 0;
    int error_reports_seen = 0;
    int stage = 0;
    int src_idle_pct = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    script_row_t script [SCRIPT_LEN] = '{
        '{8'h00, ERR_NONE},
        '{ESC_BYTE, ERR_NONE}, '{8'hFF, ERR_STX},
        '{ESC_BYTE, ERR_NONE}, '{STX_BYTE, ERR_NONE}, '{8'h00, ERR_TYPE},
        // Good three-byte frame; the escape byte is plain data inside it.
        '{ESC_BYTE, ERR_NONE}, '{STX_BYTE, ERR_NONE}, '{TYPE_LONG, ERR_NONE},
        '{8'h00, ERR_NONE}, '{8'hFF, ERR_NONE}, '{ESC_BYTE, ERR_NONE},
        '{8'hC2, ERR_NONE}, '{ESC_BYTE, ERR_NONE}, '{ETX_BYTE, ERR_NONE},
        '{ESC_BYTE, ERR_NONE}, '{STX_BYTE, ERR_NONE}, '{TYPE_A, ERR_NONE},
        '{ESC_BYTE, ERR_NONE}, '{8'h00, ERR_CHECKSUM},
        // Good checksum, but no trailer escape after it.
        '{ESC_BYTE, ERR_NONE}, '{STX_BYTE, ERR_NONE}, '{TYPE_B, ERR_NONE},
        '{8'hFF, ERR_NONE}, '{8'hDF, ERR_NONE}, '{8'h00, ERR_TRAILER},
        // Trailer escape followed by something other than ETX.
        '{ESC_BYTE, ERR_NONE}, '{STX_BYTE, ERR_NONE}, '{TYPE_C, ERR_NONE},
        '{8'h00, ERR_NONE}, '{8'hA0, ERR_NONE}, '{ESC_BYTE, ERR_NONE},
        '{8'hFF, ERR_TRAILER}
    };

    escaped_frame_receiver u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic is_known_type(input logic [7:0] t);
        return t == TYPE_A || t == TYPE_B || t == TYPE_C || t == TYPE_LONG || t == TYPE_MID;
    endfunction

    function automatic logic [1:0] payload_bytes(input logic [7:0] t);
        if (t == TYPE_LONG)
            return 2'd3;
        if (t == TYPE_MID)
            return 2'd2;
        return 2'd1;
    endfunction

    function automatic void drop_frame();
        rx_state = HUNT;
        frame_open = 1'b0;
        frame_type_q = 8'h00;
        data_cnt = 2'd0;
        frame_data = '{8'h00, 8'h00, 8'h00};
        frame_sum = 8'h00;
    endfunction

    // Advances the model by one byte. Returns 1 when the byte completes a frame
    // or ends one in error; skipped is set for idle bytes outside a frame.
    function automatic bit decode_rx_byte(input logic [7:0] b, output frame_report_t rep,
                                          output bit skipped);
        bit done;
        done = 1'b0;
        skipped = 1'b0;
        rep = '0;
        case (rx_state)
            WAIT_STX:
            begin
                if (b == STX_BYTE)
                    rx_state = WAIT_TYPE;
                else
                begin
                    rep.err = ERR_STX;
                    done = 1'b1;
                end
            end
            WAIT_TYPE:
            begin
                if (is_known_type(b))
                begin
                    frame_type_q = b;
                    frame_sum = b;
                    data_cnt = 2'd0;
                    frame_data = '{8'h00, 8'h00, 8'h00};
                    rx_state = TAKE_DATA;
                end
                else
                begin
                    rep.err = ERR_TYPE;
                    done = 1'b1;
                end
            end
            TAKE_DATA:
            begin
                if (data_cnt != 2'd3)
                    frame_data[data_cnt] = b;
                frame_sum = frame_sum ^ b;
                data_cnt = data_cnt + 2'd1;
                if (data_cnt >= payload_bytes(frame_type_q))
                    rx_state = WAIT_SUM;
            end
            WAIT_SUM:
            begin
                // On a match the frame stays open and the trailer escape is awaited.
                if (b == frame_sum)
                    rx_state = HUNT;
                else
                begin
                    rep.err = ERR_CHECKSUM;
                    done = 1'b1;
                end
            end
            WAIT_ETX:
            begin
                if (b == ETX_BYTE)
                begin
                    rep.good = 1'b1;
                    rep.err = ERR_NONE;
                    rep.type_code = frame_type_q;
                    rep.len = payload_bytes(frame_type_q);
                    rep.d0 = frame_data[0];
                    rep.d1 = frame_data[1];
                    rep.d2 = frame_data[2];
                end
                else
                    rep.err = ERR_TRAILER;
                done = 1'b1;
            end
            default:
            begin
                if (b == ESC_BYTE)
                begin
                    rx_state = frame_open ? WAIT_ETX : WAIT_STX;
                    frame_open = 1'b1;
                end
                else if (frame_open)
                begin
                    rep.err = ERR_TRAILER;
                    done = 1'b1;
                end
                else
                    skipped = 1'b1;
            end
        endcase
        if (done)
            drop_frame();
        return done;
    endfunction

    // Offers one byte, waits for the handshake and records what it should cause.
    task automatic send_byte(input logic [7:0] b, input err_code_t want);
        frame_report_t rep;
        bit has_rep;
        bit skipped;
        bit taken;
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = s_tready;
            @(posedge clk);
        end
        has_rep = decode_rx_byte(b, rep, skipped);
        if (want != ERR_NONE)
        begin
            rep = '0;
            rep.err = want;
            has_rep = 1'b1;
        end
        if (has_rep)
            pending_reports.push_back(rep);
        bytes_sent++;
        if (!skipped)
            frame_bytes++;
    endtask

    // Mostly well-formed frames with random content, some idle bytes before
    // them, and a share of corrupted, truncated or pure noise sequences.
    task automatic send_burst();
        logic [7:0] seq [$];
        logic [7:0] kinds [5];
        logic [7:0] ftype;
        logic [7:0] sum;
        logic [7:0] b;
        logic [1:0] nbytes;
        int pick;
        int pos;
        kinds = '{TYPE_A, TYPE_B, TYPE_C, TYPE_LONG, TYPE_MID};
        if ($urandom_range(19) == 0)
        begin
            repeat ($urandom_range(1, 8))
                send_byte(8'($urandom), ERR_NONE);
            return;
        end
        repeat ($urandom_range(0, 2))
        begin
            b = 8'($urandom);
            if (b == ESC_BYTE)
                b = 8'h00;
            send_byte(b, ERR_NONE);
        end
        ftype = ($urandom_range(15) == 0) ? 8'($urandom) : kinds[$urandom_range(0, 4)];
        nbytes = is_known_type(ftype) ? payload_bytes(ftype) : 2'($urandom_range(1, 3));
        seq = '{ESC_BYTE, STX_BYTE, ftype};
        sum = ftype;
        repeat (nbytes)
        begin
            b = ($urandom_range(7) == 0) ? ESC_BYTE : 8'($urandom);
            seq.push_back(b);
            sum = sum ^ b;
        end
        seq.push_back(sum);
        seq.push_back(ESC_BYTE);
        seq.push_back(ETX_BYTE);
        pick = $urandom_range(99);
        if (pick < 10)
        begin
            pos = $urandom_range(0, seq.size() - 1);
            seq[pos] = seq[pos] ^ (8'h01 << $urandom_range(0, 7));
        end
        else if (pick < 20)
        begin
            pos = $urandom_range(0, seq.size() - 1);
            seq[pos] = 8'($urandom);
        end
        else if (pick < 28)
            seq = seq[0:$urandom_range(0, seq.size() - 2)];
        foreach (seq[i])
            send_byte(seq[i], ERR_NONE);
    endtask

    task automatic flag_mismatch(input frame_report_t want, input frame_report_t seen,
                                 input bit orphan);
        mismatch_count++;
        if (mismatch_count <= SHOWN_MISMATCHES)
        begin
            if (orphan)
            begin
                $display("[%0t] result with none pending:", $realtime);
                $display("    good=%0d err=%0d type=%h len=%0d data=%h %h %h",
                         seen.good, seen.err, seen.type_code, seen.len,
                         seen.d0, seen.d1, seen.d2);
            end
            else
            begin
                $display("[%0t] result mismatch:", $realtime);
                $display("    want good=%0d err=%0d type=%h len=%0d data=%h %h %h",
                         want.good, want.err, want.type_code, want.len,
                         want.d0, want.d1, want.d2);
                $display("    got  good=%0d err=%0d type=%h len=%0d data=%h %h %h pad=%b",
                         seen.good, seen.err, seen.type_code, seen.len,
                         seen.d0, seen.d1, seen.d2, m_tdata[39:37]);
            end
        end
    endtask

    // Outputs are stable between the driving edges, so the falling edge sees
    // exactly what the next rising edge will accept.
    always @(negedge clk)
    begin
        frame_report_t seen;
        frame_report_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            seen.good = m_tuser[0];
            seen.err = err_code_t'(m_tdata[2:0]);
            seen.type_code = m_tdata[10:3];
            seen.len = m_tdata[12:11];
            seen.d0 = m_tdata[20:13];
            seen.d1 = m_tdata[28:21];
            seen.d2 = m_tdata[36:29];
            if (seen.good === 1'b1)
                good_frames_seen++;
            else
                error_reports_seen++;
            if (pending_reports.size() == 0)
                flag_mismatch(seen, seen, 1'b1);
            else
            begin
                want = pending_reports.pop_front();
                if (seen.good !== want.good || seen.err !== want.err ||
                    seen.type_code !== want.type_code || seen.len !== want.len ||
                    seen.d0 !== want.d0 || seen.d1 !== want.d1 || seen.d2 !== want.d2 ||
                    m_tdata[39:37] !== 3'b000)
                    flag_mismatch(want, seen, 1'b0);
            end
        end
    end

    // Output side: random stalls in stages 3 and 4, and one long hold at the start of
    // the first random stage so that the block backs up into its input.
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else if (stage == 1 && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else if (stage == 3)
            m_tready <= ($urandom_range(99) >= 68);
        else if (stage == 4)
            m_tready <= ($urandom_range(99) >= 20);
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results pending",
                     cycle_count, pending_reports.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        int stage_start;
        drop_frame();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
            send_byte(script[i].rx, script[i].want);

        for (int st = 1; st <= LAST_STAGE; st++)
        begin
            stage <= st;
            src_idle_pct = (st == 2) ? 68 : (st == 4) ? 20 : 0;
            stage_start = bytes_sent;
            while (bytes_sent - stage_start < ITEMS_PER_STAGE)
                send_burst();
        end
        s_tvalid <= 1'b0;

        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d bytes (%0d frame traffic) through directed, gap-free, sender-idle,",
                 bytes_sent, frame_bytes);
        $display("receiver-stall and mixed stages; checked %0d good frames, %0d error reports.",
                 good_frames_seen, error_reports_seen);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
